// ----- src/assert_macros.svh -----
// Assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock, idle during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked every clock, idle during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/dda_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package dda_pkg;
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_LINE   = 2'd2;
    localparam logic [1:0] REG_BPP    = 2'd3;

    localparam int COLOR_BITS = 24;
    localparam int OFF_BITS = 28;

    typedef struct packed {
        logic [11:0] width;
        logic [11:0] height;
        logic [15:0] line_bytes;
        logic [3:0]  bpp;
    } t_cfg;
endpackage
`default_nettype wire

// ----- src/dda_line_color_gradient.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Line stepper with a colour gradient.
// Input queue: push an item when full is low. Opcode 0 loads a segment, opcode 1
// asks for one pixel. Results: while empty is low the pixel fields are valid; pop
// takes it. A load produces nothing; a step on a finished segment produces nothing.
// Pixels come out back to back, one per cycle, while pop is high and no load runs.
// A load runs the bit-serial square root and, for a nonzero length, three serial
// divisions; steps behind it wait in a two-entry queue.
// The result register holds its item while pop is low; stepping stalls then.
// Reset (synchronous, active low) clears the queue and the segment and restores
// the register defaults: width 1920, height 1080, line 7680 bytes, 4 bytes/pixel.
// Registers: 0 width, 1 height, 2 line_bytes, 3 bytes_per_pixel at 4*i.
module dda_line_color_gradient #(
    parameter int COORD_BITS = 13,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  push,
    output logic                       full,
    input  wire logic                  i_opcode,
    input  wire logic [COORD_BITS-1:0] i_start_x,
    input  wire logic [COORD_BITS-1:0] i_start_y,
    input  wire logic [COORD_BITS-1:0] i_end_x,
    input  wire logic [COORD_BITS-1:0] i_end_y,
    input  wire logic [23:0]           i_color_start,
    input  wire logic [23:0]           i_color_end,
    output logic                       empty,
    input  wire logic                  pop,
    output logic [COORD_BITS-1:0]      o_pixel_x,
    output logic [COORD_BITS-1:0]      o_pixel_y,
    output logic [23:0]                o_pixel_color,
    output logic [27:0]                o_byte_offset,
    output logic                       o_visible,
    output logic                       o_last,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [3:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    localparam int IW = 1 + 4 * COORD_BITS + 48;
    logic [IW-1:0] w_qi;
    logic w_qv, w_qr, w_ov;
    dda_pkg::t_cfg w_cfg;

    assign pready = 1'b1;
    assign empty = !w_ov;

    // Read back the addressed register
    always_comb begin
        unique case (paddr[3:2])
            dda_pkg::REG_WIDTH:  prdata = {20'd0, w_cfg.width};
            dda_pkg::REG_HEIGHT: prdata = {20'd0, w_cfg.height};
            dda_pkg::REG_LINE:   prdata = {16'd0, w_cfg.line_bytes};
            default:             prdata = {28'd0, w_cfg.bpp};
        endcase
    end

    dda_front #(.IW(IW)) u_front (
        .i_clk, .i_rst_n, .i_push(push), .o_full(full),
        .i_item({i_opcode, i_start_x, i_start_y, i_end_x, i_end_y,
                 i_color_start, i_color_end}),
        .o_valid(w_qv), .i_ready(w_qr), .o_item(w_qi),
        .i_wr(psel && penable && pwrite && pready),
        .i_addr(paddr[3:2]), .i_wdata(pwdata), .o_cfg(w_cfg));

    dda_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk, .i_rst_n, .i_cfg(w_cfg), .i_valid(w_qv), .o_ready(w_qr),
        .i_op(w_qi[IW-1]),
        .i_sx(w_qi[48 + 3*COORD_BITS +: COORD_BITS]),
        .i_sy(w_qi[48 + 2*COORD_BITS +: COORD_BITS]),
        .i_ex(w_qi[48 + COORD_BITS +: COORD_BITS]),
        .i_ey(w_qi[48 +: COORD_BITS]),
        .i_c0(w_qi[24 +: 24]), .i_c1(w_qi[0 +: 24]),
        .o_valid(w_ov), .i_ready(pop),
        .o_px(o_pixel_x), .o_py(o_pixel_y), .o_color(o_pixel_color),
        .o_off(o_byte_offset), .o_vis(o_visible), .o_last(o_last));
endmodule
`default_nettype wire

// ----- src/dda_isqrt.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Bit-serial integer square root, two radicand bits a cycle
module dda_isqrt #(
    parameter int N_BITS = 28,
    parameter int R_BITS = 14
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [N_BITS-1:0] i_value,
    output logic                   o_done,
    output logic [R_BITS-1:0]      o_root
);
    localparam int CNT_W = $clog2(R_BITS + 1);
    logic [N_BITS-1:0] r_n, r_root, r_bit;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic [N_BITS-1:0] w_sum;

    assign w_sum = r_root + r_bit;
    assign o_root = r_root[R_BITS-1:0];

    // Walk the bit down, one step a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= r_busy && !i_start && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_n    <= i_value;
                r_root <= '0;
                r_bit  <= {{(N_BITS-1){1'b0}}, 1'b1} << (2 * (R_BITS - 1));
                r_cnt  <= CNT_W'(R_BITS);
            end else if (r_busy) begin
                if (r_n >= w_sum) begin
                    r_n    <= r_n - w_sum;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ----- src/dda_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Restoring unsigned divider, one quotient bit a cycle
module dda_div #(
    parameter int Q_BITS = 32,
    parameter int D_BITS = 14
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [Q_BITS-1:0] i_num,
    input  wire logic [D_BITS-1:0] i_den,
    output logic                   o_done,
    output logic [Q_BITS-1:0]      o_quot
);
    localparam int CNT_W = $clog2(Q_BITS + 1);
    logic [D_BITS:0]   r_rem;
    logic [D_BITS-1:0] r_den;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic [D_BITS:0]   w_shift;

    assign w_shift = {r_rem[D_BITS-1:0], o_quot[Q_BITS-1]};

    // Shift in one numerator bit, subtract where it fits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= r_busy && !i_start && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_rem  <= '0;
                r_den  <= i_den;
                o_quot <= i_num;
                r_cnt  <= CNT_W'(Q_BITS);
            end else if (r_busy) begin
                if (w_shift >= {1'b0, r_den}) begin
                    r_rem  <= w_shift - {1'b0, r_den};
                    o_quot <= {o_quot[Q_BITS-2:0], 1'b1};
                end else begin
                    r_rem  <= w_shift;
                    o_quot <= {o_quot[Q_BITS-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ----- src/dda_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Segment set-up and pixel stepping
module dda_back #(
    parameter int COORD_BITS = 13,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire dda_pkg::t_cfg         i_cfg,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic                  i_op,
    input  wire logic [COORD_BITS-1:0] i_sx,
    input  wire logic [COORD_BITS-1:0] i_sy,
    input  wire logic [COORD_BITS-1:0] i_ex,
    input  wire logic [COORD_BITS-1:0] i_ey,
    input  wire logic [23:0]           i_c0,
    input  wire logic [23:0]           i_c1,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [COORD_BITS-1:0]      o_px,
    output logic [COORD_BITS-1:0]      o_py,
    output logic [23:0]                o_color,
    output logic [27:0]                o_off,
    output logic                       o_vis,
    output logic                       o_last
);
    localparam int DW = COORD_BITS + 1;          // delta width
    localparam int SQW = 2 * DW + 1;             // dx^2+dy^2
    localparam int CW = DW + 1;                  // count width
    localparam int PW = COORD_BITS + FRAC_BITS + 1;
    localparam int NW = DW + FRAC_BITS;          // |d|<<F numerator
    localparam int QW = (NW > 25) ? NW : 25;

    typedef enum logic [2:0] {S_RUN, S_SQ, S_ROOT, S_DIVX, S_DIVY, S_DIVC} t_st;
    t_st r_st;

    logic signed [PW-1:0] r_posx, r_posy, r_incx, r_incy;
    logic signed [25:0]   r_col, r_cinc;
    logic [CW-1:0]        r_left;
    logic signed [DW-1:0] r_dx, r_dy;
    logic signed [25:0]   r_dc;
    logic [SQW-1:0]       r_sq;
    logic                 r_sq_go, r_div_go;
    logic [QW-1:0]        r_num;
    logic                 r_neg;

    logic                 w_sqrt_done, w_div_done;
    logic [CW-1:0]        w_root;
    logic [QW-1:0]        w_quot;
    logic signed [QW:0]   w_sq;

    dda_isqrt #(.N_BITS(SQW + 1), .R_BITS(CW)) u_sqrt (
        .i_clk, .i_rst_n, .i_start(r_sq_go), .i_value({1'b0, r_sq}),
        .o_done(w_sqrt_done), .o_root(w_root));
    dda_div #(.Q_BITS(QW), .D_BITS(CW)) u_div (
        .i_clk, .i_rst_n, .i_start(r_div_go), .i_num(r_num), .i_den(r_left),
        .o_done(w_div_done), .o_quot(w_quot));

    assign w_sq = r_neg ? -$signed({1'b0, w_quot}) : $signed({1'b0, w_quot});

    // Pixel view of the current position
    logic signed [COORD_BITS-1:0] w_px, w_py;
    logic signed [PW-1:0] w_tx, w_ty;
    logic w_vis, w_emit;
    logic signed [COORD_BITS:0] w_pxe, w_pye;
    assign w_tx = (r_posx < 0) ? r_posx + PW'((1 << FRAC_BITS) - 1) : r_posx;
    assign w_ty = (r_posy < 0) ? r_posy + PW'((1 << FRAC_BITS) - 1) : r_posy;
    assign w_px = w_tx[FRAC_BITS +: COORD_BITS];
    assign w_py = w_ty[FRAC_BITS +: COORD_BITS];
    assign w_pxe = COORD_BITS'(w_px);
    assign w_pye = COORD_BITS'(w_py);
    assign w_vis = (w_pxe > 0) && (w_pxe < $signed({1'b0, i_cfg.width}))
                && (w_pye > 0) && (w_pye < $signed({1'b0, i_cfg.height}));

    // Output register: hold while the sink stalls
    logic w_oflow;
    assign w_oflow = !o_valid || i_ready;
    assign o_ready = (r_st == S_RUN) && w_oflow;
    assign w_emit = o_ready && i_valid && (i_op == dda_pkg::OP_STEP) && (r_left != 0);

    logic [27:0] w_off;
    assign w_off = 28'(w_py) * 28'(i_cfg.line_bytes) + 28'(w_px) * 28'(i_cfg.bpp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_RUN; o_valid <= 1'b0; r_left <= '0;
            r_posx <= '0; r_posy <= '0; r_incx <= '0; r_incy <= '0;
            r_col <= '0; r_cinc <= '0; r_sq_go <= 1'b0; r_div_go <= 1'b0;
        end else begin
            // Pulse the square root and divider starts
            r_sq_go <= (r_st == S_SQ);
            r_div_go <= ((r_st == S_ROOT) && w_sqrt_done && (w_root != '0))
                     || (((r_st == S_DIVX) || (r_st == S_DIVY)) && w_div_done);
            if (w_emit) o_valid <= 1'b1;
            else if (i_ready) o_valid <= 1'b0;
            unique case (r_st)
                S_RUN: begin
                    if (w_emit) begin
                        o_px <= w_px; o_py <= w_py; o_color <= r_col[23:0];
                        o_vis <= w_vis; o_off <= w_vis ? w_off : '0;
                        o_last <= (r_left == CW'(1));
                        r_posx <= r_posx + r_incx; r_posy <= r_posy + r_incy;
                        r_col <= r_col + r_cinc; r_left <= r_left - 1'b1;
                    end else if (o_ready && i_valid && i_op == dda_pkg::OP_LOAD) begin
                        r_dx <= $signed({i_ex[COORD_BITS-1], i_ex})
                              - $signed({i_sx[COORD_BITS-1], i_sx});
                        r_dy <= $signed({i_ey[COORD_BITS-1], i_ey})
                              - $signed({i_sy[COORD_BITS-1], i_sy});
                        r_dc <= $signed({2'b0, i_c1}) - $signed({2'b0, i_c0});
                        r_posx <= $signed({i_sx, {FRAC_BITS{1'b0}}});
                        r_posy <= $signed({i_sy, {FRAC_BITS{1'b0}}});
                        r_col <= $signed({2'b0, i_c0});
                        r_incx <= '0; r_incy <= '0; r_cinc <= '0;
                        r_st <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_sq <= SQW'(r_dx * r_dx) + SQW'(r_dy * r_dy);
                    r_st <= S_ROOT;
                end
                S_ROOT: if (w_sqrt_done) begin
                    r_left <= w_root;
                    r_neg <= r_dx[DW-1];
                    r_num <= QW'(r_dx[DW-1] ? -r_dx : r_dx) << FRAC_BITS;
                    if (w_root == 0) r_st <= S_RUN;
                    else r_st <= S_DIVX;
                end
                S_DIVX: if (w_div_done) begin
                    r_incx <= PW'(w_sq);
                    r_neg <= r_dy[DW-1];
                    r_num <= QW'(r_dy[DW-1] ? -r_dy : r_dy) << FRAC_BITS;
                    r_st <= S_DIVY;
                end
                S_DIVY: if (w_div_done) begin
                    r_incy <= PW'(w_sq);
                    r_neg <= r_dc[25];
                    r_num <= QW'(r_dc[25] ? -r_dc : r_dc);
                    r_st <= S_DIVC;
                end
                S_DIVC: if (w_div_done) begin
                    r_cinc <= 26'(w_sq);
                    r_st <= S_RUN;
                end
                default: r_st <= S_RUN;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- src/dda_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Input queue of two items and register file
module dda_front #(
    parameter int IW = 101
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    output logic               o_full,
    input  wire logic [IW-1:0] i_item,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [IW-1:0]      o_item,
    input  wire logic          i_wr,
    input  wire logic [1:0]    i_addr,
    input  wire logic [31:0]   i_wdata,
    output dda_pkg::t_cfg      o_cfg
);
    logic [IW-1:0] r_q [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          w_in, w_out;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];
    assign w_in    = i_push && !o_full;
    assign w_out   = o_valid && i_ready;

    // Advance pointers, write entries
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (w_in) begin r_q[r_wp] <= i_item; r_wp <= ~r_wp; end
            if (w_out) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_in} - {1'b0, w_out};
        end
    end

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_cfg.width <= 12'd1920; o_cfg.height <= 12'd1080;
            o_cfg.line_bytes <= 16'd7680; o_cfg.bpp <= 4'd4;
        end else if (i_wr) begin
            unique case (i_addr)
                dda_pkg::REG_WIDTH:  o_cfg.width <= i_wdata[11:0];
                dda_pkg::REG_HEIGHT: o_cfg.height <= i_wdata[11:0];
                dda_pkg::REG_LINE:   o_cfg.line_bytes <= i_wdata[15:0];
                dda_pkg::REG_BPP:    o_cfg.bpp <= i_wdata[3:0];
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- src/dda_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Port-level checks
module dda_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic        o_visible,
    input wire logic [27:0] o_byte_offset,
    input wire logic        pready
);
    `ASSERT_IMPL(a_hidden_zero, i_clk, i_rst_n, !empty && !o_visible, o_byte_offset == 28'd0, "hidden pixel with offset")
    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_byte_offset), "result dropped under stall")
    `ASSERT_IMPL(a_ready, i_clk, i_rst_n, 1'b1, pready, "pready low")
endmodule
bind dda_line_color_gradient dda_checker u_chk (.i_clk, .i_rst_n, .empty, .pop,
    .o_visible, .o_byte_offset, .pready);
`default_nettype wire

// ----- bench/dda_line_color_gradient_tb.sv -----
`timescale 1ns / 1ps
module dda_line_color_gradient_tb;
    import dda_pkg::*;

    localparam int  CB          = 13;
    localparam int  FB          = 16;
    localparam int  CYCLE_LIMIT = 900000;
    localparam int  LOAD_CYCLES = 250;

    typedef struct {
        logic [CB-1:0]         px;
        logic [CB-1:0]         py;
        logic [COLOR_BITS-1:0] color;
        logic [OFF_BITS-1:0]   offset;
        logic                  vis;
        logic                  last;
    } t_pixel;

    // Segment stepper model and queue of pixels still owed by the block
    class pixel_scoreboard;
        t_pixel  owed[$];
        t_cfg    cfg;
        longint  pos_x, pos_y, inc_x, inc_y, col_now, col_inc;
        int      left;
        int      errors, loads, pixels;

        function new();
            cfg = '{width: 12'd1920, height: 12'd1080, line_bytes: 16'd7680, bpp: 4'd4};
            pos_x = 0; pos_y = 0; inc_x = 0; inc_y = 0;
            col_now = 0; col_inc = 0; left = 0;
            errors = 0; loads = 0; pixels = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_WIDTH:  cfg.width = val[11:0];
                REG_HEIGHT: cfg.height = val[11:0];
                REG_LINE:   cfg.line_bytes = val[15:0];
                REG_BPP:    cfg.bpp = val[3:0];
                default: ;
            endcase
        endfunction

        // Integer square root, two bits per pass
        function longint root_of(longint unsigned n);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n) b >>= 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return longint'(r);
        endfunction

        function void note_item(logic op, logic signed [CB-1:0] sx, logic signed [CB-1:0] sy,
                                logic signed [CB-1:0] ex, logic signed [CB-1:0] ey,
                                logic [23:0] c0, logic [23:0] c1);
            longint dx, dy, n, px, py, off;
            t_pixel p;
            bit     v;
            if (op == OP_LOAD) begin
                loads++;
                dx = longint'(ex) - longint'(sx);
                dy = longint'(ey) - longint'(sy);
                n = root_of(longint'(dx * dx + dy * dy));
                pos_x = longint'(sx) * (64'sd1 << FB);
                pos_y = longint'(sy) * (64'sd1 << FB);
                col_now = longint'({40'd0, c0});
                left = int'(n);
                if (n > 0) begin
                    inc_x = (dx * (64'sd1 << FB)) / n;
                    inc_y = (dy * (64'sd1 << FB)) / n;
                    col_inc = (longint'({40'd0, c1}) - col_now) / n;
                end else begin
                    inc_x = 0; inc_y = 0; col_inc = 0;
                end
                return;
            end
            if (left == 0) return;
            // Truncate toward zero, not floor
            px = pos_x / (64'sd1 << FB);
            py = pos_y / (64'sd1 << FB);
            v = px > 0 && px < longint'(cfg.width) && py > 0 && py < longint'(cfg.height);
            off = v ? py * longint'(cfg.line_bytes) + px * longint'(cfg.bpp) : 0;
            p.px = px[CB-1:0];
            p.py = py[CB-1:0];
            p.color = col_now[23:0];
            p.offset = off[27:0];
            p.vis = v;
            p.last = (left == 1);
            owed.push_back(p);
            pos_x += inc_x;
            pos_y += inc_y;
            col_now += col_inc;
            left--;
        endfunction

        function void check_pixel(t_pixel got);
            t_pixel w;
            if (owed.size() == 0) begin
                $error("pixel popped with nothing owed: x=%0d y=%0d", got.px, got.py);
                errors++;
                return;
            end
            w = owed.pop_front();
            pixels++;
            if (got.px !== w.px) begin
                $error("pixel_x expected %0h actual %0h", w.px, got.px); errors++;
            end
            if (got.py !== w.py) begin
                $error("pixel_y expected %0h actual %0h", w.py, got.py); errors++;
            end
            if (got.color !== w.color) begin
                $error("pixel_color expected %0h actual %0h", w.color, got.color); errors++;
            end
            if (got.offset !== w.offset) begin
                $error("byte_offset expected %0h actual %0h", w.offset, got.offset); errors++;
            end
            if (got.vis !== w.vis) begin
                $error("visible expected %0b actual %0b", w.vis, got.vis); errors++;
            end
            if (got.last !== w.last) begin
                $error("last expected %0b actual %0b", w.last, got.last); errors++;
            end
        endfunction
    endclass

    logic                  i_clk, i_rst_n;
    logic                  push, full, empty, pop;
    logic                  i_opcode;
    logic [CB-1:0]         i_start_x, i_start_y, i_end_x, i_end_y;
    logic [23:0]           i_color_start, i_color_end;
    logic [CB-1:0]         o_pixel_x, o_pixel_y;
    logic [23:0]           o_pixel_color;
    logic [27:0]           o_byte_offset;
    logic                  o_visible, o_last;
    logic                  psel, penable, pwrite, pready;
    logic [3:0]            paddr;
    logic [31:0]           pwdata, prdata;

    pixel_scoreboard sb;
    int  send_idle, recv_idle, hold_left, cycles, items;
    bit  hold_req;

    dda_line_color_gradient #(.COORD_BITS(CB), .FRAC_BITS(FB)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_opcode(i_opcode), .i_start_x(i_start_x), .i_start_y(i_start_y),
        .i_end_x(i_end_x), .i_end_y(i_end_y),
        .i_color_start(i_color_start), .i_color_end(i_color_end),
        .empty(empty), .pop(pop), .o_pixel_x(o_pixel_x), .o_pixel_y(o_pixel_y),
        .o_pixel_color(o_pixel_color), .o_byte_offset(o_byte_offset),
        .o_visible(o_visible), .o_last(o_last),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Pop side: check each accepted pixel, stall at random or for a long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty)
                sb.check_pixel('{px: o_pixel_x, py: o_pixel_y, color: o_pixel_color,
                                 offset: o_byte_offset, vis: o_visible, last: o_last});
            if (hold_req) begin
                hold_left = 400;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    // Offer one item and hold it until accepted, with an optional gap first
    task automatic send_item(logic op, logic [CB-1:0] sx, logic [CB-1:0] sy,
                             logic [CB-1:0] ex, logic [CB-1:0] ey,
                             logic [23:0] c0, logic [23:0] c1);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle && gap < 6) gap++;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_opcode <= op;
        i_start_x <= sx; i_start_y <= sy; i_end_x <= ex; i_end_y <= ey;
        i_color_start <= c0; i_color_end <= c1;
        do @(posedge i_clk); while (full);
        sb.note_item(op, sx, sy, ex, ey, c0, c1);
        items++;
    endtask

    task automatic step_pixels(int n);
        repeat (n) send_item(OP_STEP, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom);
    endtask

    // Wait until every owed pixel is out and any trailing load has settled
    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (LOAD_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        sb.set_reg(idx, val);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_regs(logic [31:0] w, logic [31:0] h, logic [31:0] lb, logic [31:0] bpp);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_LINE, lb);
        write_reg(REG_BPP, bpp);
    endtask

    // Mostly short segments stepped to the end, some cut short, some noise
    task automatic random_traffic(int n);
        int start_items, sx, sy, dx, dy, span, steps;
        start_items = items;
        while (items - start_items < n) begin
            if ($urandom_range(99) < 80) begin
                span = ($urandom_range(9) == 0) ? 200 : 12;
                if ($urandom_range(5) == 0) begin
                    sx = $urandom_range(8191) - 4096;
                    sy = $urandom_range(8191) - 4096;
                end else begin
                    sx = $urandom_range(2100) - 50;
                    sy = $urandom_range(1200) - 50;
                end
                dx = $urandom_range(2 * span) - span;
                dy = $urandom_range(2 * span) - span;
                if (sx + dx > 4095 || sx + dx < -4096) dx = -dx;
                if (sy + dy > 4095 || sy + dy < -4096) dy = -dy;
                send_item(OP_LOAD, sx, sy, sx + dx, sy + dy, $urandom, $urandom);
                steps = sb.left + $urandom_range(2);
                if ($urandom_range(7) == 0) steps = $urandom_range(steps);
                if (steps > 40) steps = 40;
                step_pixels(steps);
            end else begin
                send_item($urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom);
            end
        end
    endtask

    initial begin
        sb = new();
        cycles = 0; items = 0; hold_left = 0; hold_req = 1'b0;
        send_idle = 0; recv_idle = 0;
        i_rst_n <= 1'b0;
        push <= 1'b0; i_opcode <= OP_LOAD;
        i_start_x <= '0; i_start_y <= '0; i_end_x <= '0; i_end_y <= '0;
        i_color_start <= '0; i_color_end <= '0;
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: step while idle, 3-4-5 segment, zero length, extreme corners
        step_pixels(1);
        send_item(OP_LOAD, 13'd0, 13'd0, 13'd3, 13'd4, 24'h000000, 24'hFFFFFF);
        step_pixels(6);
        send_item(OP_LOAD, 13'd100, 13'd100, 13'd100, 13'd100, 24'h123456, 24'hFFFFFF);
        step_pixels(1);
        send_item(OP_LOAD, -13'sd4096, -13'sd4096, 13'sd4095, 13'sd4095,
                  24'hFFFFFF, 24'h000000);
        step_pixels(2);
        // Load mid-segment replaces it; falling colour and negative y
        send_item(OP_LOAD, 13'd10, 13'd10, 13'd10, 13'd2, 24'hFFFFFF, 24'h000000);
        step_pixels(9);
        send_item(OP_LOAD, 13'sd4095, 13'sd4095, -13'sd4096, 13'sd4095,
                  24'h000000, 24'hFFFFFF);
        step_pixels(2);
        drain();

        // Wide bounds and maximum sizes; the largest offset still fits in 28 bits
        set_regs(32'd4095, 32'd4095, 32'd65535, 32'd15);
        send_idle = 35; recv_idle = 62;
        random_traffic(250);
        drain();

        // Zero width and sizes, then the other idling mix
        set_regs(32'd0, 32'd4095, 32'd0, 32'd0);
        send_idle = 62; recv_idle = 35;
        random_traffic(120);
        drain();
        set_regs(32'd1, 32'd1, 32'd1, 32'd1);
        random_traffic(80);
        drain();

        // Full rate, with one long receiver hold-off to back the queue up
        set_regs(32'd640, 32'd480, 32'd2560, 32'd8);
        send_idle = 0; recv_idle = 0;
        random_traffic(40);
        hold_req = 1'b1;
        random_traffic(260);
        drain();

        $display("covered %0d items: %0d segment loads, %0d pixels checked",
                 items, sb.loads, sb.pixels);
        $display("register sets: reset values, maxima, zeros, ones and a VGA-like mode");
        if (sb.errors == 0 && sb.owed.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+src
src/dda_pkg.sv
src/dda_isqrt.sv
src/dda_div.sv
src/dda_back.sv
src/dda_front.sv
src/dda_line_color_gradient.sv
src/dda_checker.sv
bench/dda_line_color_gradient_tb.sv
